// ===== rtl/differential_drive_sync_controller_assert.svh =====
// Assertion macros for the differential drive sync controller.
`ifndef DIFFERENTIAL_DRIVE_SYNC_CONTROLLER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_SYNC_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DDSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ddsc same-cycle check failed");

// next-cycle implication, checked out of reset
`define DDSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ddsc next-cycle check failed");

`endif

// ===== rtl/ddsc_pkg.sv =====
// Shared types and constants of the differential drive sync controller.
package ddsc_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_ENC_A = 2'd1,
        KIND_ENC_B = 2'd2,
        KIND_TICK  = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic       at_target;
    } sync_res_t;

    localparam logic [7:0] CH_FWD_LO   = 8'h77;
    localparam logic [7:0] CH_FWD_UP   = 8'h57;
    localparam logic [7:0] CH_REV_LO   = 8'h73;
    localparam logic [7:0] CH_REV_UP   = 8'h53;
    localparam logic [7:0] CH_LEFT_LO  = 8'h61;
    localparam logic [7:0] CH_LEFT_UP  = 8'h41;
    localparam logic [7:0] CH_RIGHT_LO = 8'h64;
    localparam logic [7:0] CH_RIGHT_UP = 8'h44;
    localparam logic [7:0] CH_STOP_LO  = 8'h78;
    localparam logic [7:0] CH_STOP_UP  = 8'h58;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DIST_LO  = 8'h6d;
    localparam logic [7:0] CH_DIST_UP  = 8'h4d;
    localparam logic [7:0] CH_PLUS     = 8'h2b;
    localparam logic [7:0] CH_MINUS    = 8'h2d;

    localparam logic [3:0] DIR_NONE  = 4'b0000;
    localparam logic [3:0] DIR_FWD   = 4'b0101;
    localparam logic [3:0] DIR_REV   = 4'b1010;
    localparam logic [3:0] DIR_LEFT  = 4'b0110;
    localparam logic [3:0] DIR_RIGHT = 4'b1001;

    localparam logic [7:0] BASE_MIN   = 8'd50;
    localparam logic [7:0] BASE_MAX   = 8'd255;
    localparam logic [7:0] BASE_STEP  = 8'd15;
    localparam logic [7:0] BASE_RESET = 8'd200;

    localparam logic [7:0]  KP_RESET   = 8'd24;
    localparam logic [19:0] DIST_RESET = 20'd1463;

    localparam logic REG_KP   = 1'b0;
    localparam logic REG_DIST = 1'b1;

endpackage

// ===== rtl/ddsc_sync.sv =====
// Proportional wheel sync duties and distance compare for one control tick.
module ddsc_sync
    import ddsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic [COUNT_WIDTH-1:0] count_a,
    input  logic [COUNT_WIDTH-1:0] count_b,
    input  logic [7:0]             base_speed,
    input  logic [7:0]             kp_gain,
    input  logic [19:0]            dist_target,
    output sync_res_t              res
);

    localparam int ERR_W  = COUNT_WIDTH + 1;
    localparam int PROD_W = COUNT_WIDTH + 10;
    localparam int SUM_W  = COUNT_WIDTH + 11;
    localparam int CMP_W  = (COUNT_WIDTH > 20) ? COUNT_WIDTH : 20;

    logic [COUNT_WIDTH-1:0]  mag_a;
    logic [COUNT_WIDTH-1:0]  mag_b;
    logic signed [ERR_W-1:0] err;
    logic signed [8:0]       kp_s;
    logic signed [PROD_W-1:0] corr;
    logic signed [SUM_W-1:0] base16;
    logic signed [SUM_W-1:0] sum_a;
    logic signed [SUM_W-1:0] sum_b;

    function automatic logic [7:0] sat_duty(input logic signed [SUM_W-1:0] v);
        logic [7:0] d;
        if (v[SUM_W-1]) begin
            d = 8'd0;
        end else if (|v[SUM_W-2:12]) begin
            d = 8'd255;
        end else begin
            d = v[11:4];
        end
        return d;
    endfunction

    assign mag_a  = count_a[COUNT_WIDTH-1] ? (~count_a + COUNT_WIDTH'(1)) : count_a;
    assign mag_b  = count_b[COUNT_WIDTH-1] ? (~count_b + COUNT_WIDTH'(1)) : count_b;
    assign err    = $signed({1'b0, mag_a}) - $signed({1'b0, mag_b});
    assign kp_s   = $signed({1'b0, kp_gain});
    assign corr   = PROD_W'(err) * PROD_W'(kp_s);
    assign base16 = $signed(SUM_W'({base_speed, 4'b0000}));
    assign sum_a  = base16 - SUM_W'(corr);
    assign sum_b  = base16 + SUM_W'(corr);

    assign res.duty_a    = sat_duty(sum_a);
    assign res.duty_b    = sat_duty(sum_b);
    assign res.at_target = CMP_W'(mag_a) >= CMP_W'(dist_target);

endmodule

// ===== rtl/differential_drive_sync_controller.sv =====
// Two-wheel drive controller: commands, encoder counting and proportional wheel sync.
// One event enters per transfer on the s_ channel and produces exactly one status
// transfer on the m_ channel showing the state after that event. The block takes a
// new event every clock cycle unless m_tready stalls the status output; an event
// passes the input register, then the state register that also serves as the result
// register. The clock rate is set by the combinational state update, whose longest
// path on a tick is count magnitude, difference, one gain multiply, add and saturate.
// kp_gain is unsigned Q4.4. Write configuration only while no event is in flight.
module differential_drive_sync_controller
    import ddsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd_byte[7:0], phase_level[8], zero pad
    input  logic [1:0]  s_tuser,   // event kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // speed_a[7:0], speed_b[15:8], a_fwd[16], a_rev[17],
                                   // b_fwd[18], b_rev[19], count_a[51:20],
                                   // count_b[83:52], target_reached[84],
                                   // base_now[92:85], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "differential_drive_sync_controller_assert.svh"

    localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic                   in_valid_reg, in_valid_next;
    event_kind_t            in_kind_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_level_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [COUNT_WIDTH-1:0] count_a_reg, count_a_next;
    logic [COUNT_WIDTH-1:0] count_b_reg, count_b_next;
    logic [7:0]             base_reg, base_next;
    logic                   straight_reg, straight_next;
    logic                   distance_reg, distance_next;
    logic [7:0]             pwm_a_reg, pwm_a_next;
    logic [7:0]             pwm_b_reg, pwm_b_next;
    logic [3:0]             dir_reg, dir_next;
    logic                   reached_reg, reached_next;

    logic [7:0]             kp_reg;
    logic [19:0]            dist_reg;

    logic                   s_accept;
    logic                   advance;
    logic                   cfg_write;
    sync_res_t              sync_res;
    logic signed [EXT_W-1:0] count_a_ext;
    logic signed [EXT_W-1:0] count_b_ext;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= KP_RESET;
            dist_reg <= DIST_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_KP:   kp_reg   <= pwdata[7:0];
                REG_DIST: dist_reg <= pwdata[19:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_KP:   prdata = {24'd0, kp_reg};
            REG_DIST: prdata = {12'd0, dist_reg};
            default:  prdata = 32'd0;
        endcase
    end

    // input stage
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg  <= event_kind_t'(s_tuser);
            in_byte_reg  <= s_tdata[7:0];
            in_level_reg <= s_tdata[8];
        end
    end

    ddsc_sync #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_sync (
        .count_a    (count_a_reg),
        .count_b    (count_b_reg),
        .base_speed (base_reg),
        .kp_gain    (kp_reg),
        .dist_target(dist_reg),
        .res        (sync_res)
    );

    // state update for the event in the input stage
    always_comb begin
        m_valid_next  = m_valid_reg;
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        base_next     = base_reg;
        straight_next = straight_reg;
        distance_next = distance_reg;
        pwm_a_next    = pwm_a_reg;
        pwm_b_next    = pwm_b_reg;
        dir_next      = dir_reg;
        reached_next  = reached_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next = 1'b1;
            reached_next = 1'b0;
            case (in_kind_reg)
                KIND_BYTE: begin
                    case (in_byte_reg)
                        CH_FWD_LO, CH_FWD_UP: begin
                            straight_next = 1'b1;
                            dir_next      = DIR_FWD;
                            pwm_a_next    = base_reg;
                            pwm_b_next    = base_reg;
                        end
                        CH_REV_LO, CH_REV_UP: begin
                            straight_next = 1'b1;
                            dir_next      = DIR_REV;
                            pwm_a_next    = base_reg;
                            pwm_b_next    = base_reg;
                        end
                        CH_LEFT_LO, CH_LEFT_UP: begin
                            straight_next = 1'b0;
                            distance_next = 1'b0;
                            dir_next      = DIR_LEFT;
                            pwm_a_next    = base_reg;
                            pwm_b_next    = base_reg;
                        end
                        CH_RIGHT_LO, CH_RIGHT_UP: begin
                            straight_next = 1'b0;
                            distance_next = 1'b0;
                            dir_next      = DIR_RIGHT;
                            pwm_a_next    = base_reg;
                            pwm_b_next    = base_reg;
                        end
                        CH_STOP_LO, CH_STOP_UP, CH_SPACE: begin
                            straight_next = 1'b0;
                            distance_next = 1'b0;
                            dir_next      = DIR_NONE;
                            pwm_a_next    = 8'd0;
                            pwm_b_next    = 8'd0;
                        end
                        CH_DIST_LO, CH_DIST_UP: begin
                            straight_next = 1'b1;
                            distance_next = 1'b1;
                            dir_next      = DIR_FWD;
                            pwm_a_next    = base_reg;
                            pwm_b_next    = base_reg;
                        end
                        CH_PLUS: begin
                            base_next = (base_reg > BASE_MAX - BASE_STEP) ?
                                        BASE_MAX : base_reg + BASE_STEP;
                        end
                        CH_MINUS: begin
                            base_next = (base_reg < BASE_MIN + BASE_STEP) ?
                                        BASE_MIN : base_reg - BASE_STEP;
                        end
                        default: ;
                    endcase
                end
                KIND_ENC_A: begin
                    count_a_next = in_level_reg ? count_a_reg - COUNT_WIDTH'(1)
                                                : count_a_reg + COUNT_WIDTH'(1);
                end
                KIND_ENC_B: begin
                    count_b_next = in_level_reg ? count_b_reg + COUNT_WIDTH'(1)
                                                : count_b_reg - COUNT_WIDTH'(1);
                end
                KIND_TICK: begin
                    if (straight_reg) begin
                        pwm_a_next = sync_res.duty_a;
                        pwm_b_next = sync_res.duty_b;
                    end
                    if (distance_reg && sync_res.at_target) begin
                        straight_next = 1'b0;
                        distance_next = 1'b0;
                        dir_next      = DIR_NONE;
                        pwm_a_next    = 8'd0;
                        pwm_b_next    = 8'd0;
                        reached_next  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            base_reg     <= BASE_RESET;
            straight_reg <= 1'b0;
            distance_reg <= 1'b0;
            pwm_a_reg    <= 8'd0;
            pwm_b_reg    <= 8'd0;
            dir_reg      <= DIR_NONE;
            reached_reg  <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            count_a_reg  <= count_a_next;
            count_b_reg  <= count_b_next;
            base_reg     <= base_next;
            straight_reg <= straight_next;
            distance_reg <= distance_next;
            pwm_a_reg    <= pwm_a_next;
            pwm_b_reg    <= pwm_b_next;
            dir_reg      <= dir_next;
            reached_reg  <= reached_next;
        end
    end

    assign count_a_ext = EXT_W'($signed(count_a_reg));
    assign count_b_ext = EXT_W'($signed(count_b_reg));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, base_reg, reached_reg, count_b_ext[31:0], count_a_ext[31:0],
                       dir_reg, pwm_b_reg, pwm_a_reg};

    `DDSC_ASSERT_NOW(a_reached_halts, m_tvalid && m_tdata[84], m_tdata[19:0] == 20'd0)
    `DDSC_ASSERT_NOW(a_distance_straight, distance_reg, straight_reg)
    `DDSC_ASSERT_NEXT(a_advance_shows, advance, m_valid_reg)
    `DDSC_ASSERT_NOW(a_base_floor, m_valid_reg, base_reg >= BASE_MIN)

endmodule

// ===== bench/drive_status_checker.sv =====
// Status checker for the drive controller: predicts each status transfer and compares it.
`timescale 1ns / 100ps

module drive_status_checker
    import ddsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          pending,
    output int          errors
);

    localparam longint DUTY_SCALE = 16;
    localparam longint DUTY_MAX   = 255;

    typedef struct {
        logic [7:0]  speed_a;
        logic [7:0]  speed_b;
        logic        a_fwd;
        logic        a_rev;
        logic        b_fwd;
        logic        b_rev;
        logic [31:0] count_a;
        logic [31:0] count_b;
        logic        target_reached;
        logic [7:0]  base_now;
    } drive_status_t;

    logic [COUNT_WIDTH-1:0] cnt_a;
    logic [COUNT_WIDTH-1:0] cnt_b;
    logic [7:0]             base_speed;
    logic [7:0]             duty_a;
    logic [7:0]             duty_b;
    logic [3:0]             dirs;
    logic                   straight_on;
    logic                   distance_on;
    logic [7:0]             kp_gain;
    logic [19:0]            dist_target;
    drive_status_t          status_q[$];

    function automatic longint count_mag(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH-1:0] m;
        m = c[COUNT_WIDTH-1] ? -c : c;
        return longint'({{(64-COUNT_WIDTH){1'b0}}, m});
    endfunction

    function automatic logic [31:0] count_view(input logic [COUNT_WIDTH-1:0] c);
        longint s;
        s = longint'(signed'(c));
        return s[31:0];
    endfunction

    function automatic logic [7:0] clamp_duty(input longint scaled);
        longint v;
        v = scaled / DUTY_SCALE;
        if (v < 0)
            return 8'd0;
        if (v > DUTY_MAX)
            return 8'd255;
        return v[7:0];
    endfunction

    task automatic stop_motors();
        straight_on = 1'b0;
        distance_on = 1'b0;
        duty_a      = 8'd0;
        duty_b      = 8'd0;
        dirs        = DIR_NONE;
    endtask

    task automatic set_drive(input logic straight, input logic [3:0] d);
        straight_on = straight;
        if (!straight)
            distance_on = 1'b0;
        dirs   = d;
        duty_a = base_speed;
        duty_b = base_speed;
    endtask

    task automatic apply_command(input logic [7:0] ch);
        case (ch)
            CH_FWD_LO, CH_FWD_UP:     set_drive(1'b1, DIR_FWD);
            CH_REV_LO, CH_REV_UP:     set_drive(1'b1, DIR_REV);
            CH_LEFT_LO, CH_LEFT_UP:   set_drive(1'b0, DIR_LEFT);
            CH_RIGHT_LO, CH_RIGHT_UP: set_drive(1'b0, DIR_RIGHT);
            CH_STOP_LO, CH_STOP_UP, CH_SPACE: stop_motors();
            CH_DIST_LO, CH_DIST_UP: begin
                distance_on = 1'b1;
                set_drive(1'b1, DIR_FWD);
            end
            CH_PLUS: begin
                base_speed = (base_speed > BASE_MAX - BASE_STEP) ? BASE_MAX
                                                                 : base_speed + BASE_STEP;
            end
            CH_MINUS: begin
                base_speed = (base_speed < BASE_MIN + BASE_STEP) ? BASE_MIN
                                                                 : base_speed - BASE_STEP;
            end
            default: ;
        endcase
    endtask

    task automatic apply_event(input event_kind_t kind, input logic [7:0] ch,
                               input logic level, output drive_status_t st);
        logic   reached;
        longint err;
        longint corr;
        longint b16;
        reached = 1'b0;
        case (kind)
            KIND_BYTE:  apply_command(ch);
            KIND_ENC_A: cnt_a = level ? cnt_a - 1'b1 : cnt_a + 1'b1;
            KIND_ENC_B: cnt_b = level ? cnt_b + 1'b1 : cnt_b - 1'b1;
            default: begin
                if (straight_on) begin
                    err    = count_mag(cnt_a) - count_mag(cnt_b);
                    corr   = err * longint'(kp_gain);
                    b16    = longint'(base_speed) * DUTY_SCALE;
                    duty_a = clamp_duty(b16 - corr);
                    duty_b = clamp_duty(b16 + corr);
                end
                if (distance_on && count_mag(cnt_a) >= longint'(dist_target)) begin
                    stop_motors();
                    reached = 1'b1;
                end
            end
        endcase
        st.speed_a        = duty_a;
        st.speed_b        = duty_b;
        st.a_fwd          = dirs[0];
        st.a_rev          = dirs[1];
        st.b_fwd          = dirs[2];
        st.b_rev          = dirs[3];
        st.count_a        = count_view(cnt_a);
        st.count_b        = count_view(cnt_b);
        st.target_reached = reached;
        st.base_now       = base_speed;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        drive_status_t predicted;
        if (!aresetn) begin
            cnt_a       = '0;
            cnt_b       = '0;
            base_speed  = BASE_RESET;
            stop_motors();
            kp_gain     = KP_RESET;
            dist_target = DIST_RESET;
            status_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_KP, 2'b00})
                    kp_gain = pwdata[7:0];
                else if (paddr == {REG_DIST, 2'b00})
                    dist_target = pwdata[19:0];
            end
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $error("status transfer with no event outstanding");
                    errors++;
                end else begin
                    predicted = status_q.pop_front();
                    check_field("speed_a", predicted.speed_a, m_tdata[7:0]);
                    check_field("speed_b", predicted.speed_b, m_tdata[15:8]);
                    check_field("a_fwd", predicted.a_fwd, m_tdata[16]);
                    check_field("a_rev", predicted.a_rev, m_tdata[17]);
                    check_field("b_fwd", predicted.b_fwd, m_tdata[18]);
                    check_field("b_rev", predicted.b_rev, m_tdata[19]);
                    check_field("count_a", predicted.count_a, m_tdata[51:20]);
                    check_field("count_b", predicted.count_b, m_tdata[83:52]);
                    check_field("target_reached", predicted.target_reached, m_tdata[84]);
                    check_field("base_now", predicted.base_now, m_tdata[92:85]);
                end
            end
            if (s_tvalid && s_tready) begin
                apply_event(event_kind_t'(s_tuser), s_tdata[7:0], s_tdata[8], predicted);
                status_q.push_back(predicted);
            end
        end
        pending <= status_q.size();
    end

endmodule

// ===== bench/tb_differential_drive_sync_controller.sv =====
// Testbench top for the drive controller: event stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb_differential_drive_sync_controller;
    import ddsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 175;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          errors;
    int          burst_left  = 0;
    int          cycle_count = 0;
    int          ready_tick  = 0;
    ready_mode_t ready_mode  = READY_ALWAYS;

    differential_drive_sync_controller DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    drive_status_checker status_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pending  (pending),
        .errors   (errors)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 256 == 0)
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_MOSTLY:   m_tready <= ($urandom_range(0, 9) < 7);
            READY_PERIODIC: m_tready <= (ready_tick % 5 != 0);
            default:        m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    function automatic logic [7:0] drive_char(input int idx);
        case (idx)
            0:       return CH_FWD_LO;
            1:       return CH_FWD_UP;
            2:       return CH_REV_LO;
            3:       return CH_REV_UP;
            4:       return CH_LEFT_LO;
            5:       return CH_LEFT_UP;
            6:       return CH_RIGHT_LO;
            7:       return CH_RIGHT_UP;
            8:       return CH_STOP_LO;
            9:       return CH_STOP_UP;
            10:      return CH_SPACE;
            11:      return CH_DIST_LO;
            default: return CH_DIST_UP;
        endcase
    endfunction

    task automatic send_event(input event_kind_t kind, input logic [7:0] ch, input logic level);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, level, ch};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int          phase;
        int          item;
        int          r;
        logic [7:0]  ch;
        logic [7:0]  favored;
        logic [7:0]  kp;
        logic [19:0] dist_ticks;
        logic        a_dir;
        logic        b_dir;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_event(KIND_TICK, 8'h00, 1'b0);
        send_event(KIND_ENC_A, 8'hFF, 1'b0);
        send_event(KIND_ENC_A, 8'h00, 1'b1);
        send_event(KIND_ENC_B, 8'h00, 1'b1);
        send_event(KIND_ENC_B, 8'hFF, 1'b0);
        send_event(KIND_BYTE, CH_FWD_LO, 1'b1);
        send_event(KIND_TICK, 8'h00, 1'b1);
        send_event(KIND_BYTE, CH_REV_UP, 1'b0);
        send_event(KIND_BYTE, CH_LEFT_LO, 1'b0);
        send_event(KIND_BYTE, CH_RIGHT_UP, 1'b0);
        send_event(KIND_BYTE, CH_STOP_LO, 1'b0);
        send_event(KIND_BYTE, CH_DIST_UP, 1'b0);
        send_event(KIND_BYTE, CH_SPACE, 1'b0);
        for (item = 0; item < 4; item++)
            send_event(KIND_BYTE, CH_PLUS, 1'b0);
        for (item = 0; item < 11; item++)
            send_event(KIND_BYTE, CH_MINUS, 1'b0);
        send_event(KIND_BYTE, 8'hFF, 1'b1);
        send_event(KIND_BYTE, 8'h00, 1'b0);

        // distance drive that ends on a tick, with maximum gain
        wait_idle();
        write_reg(REG_DIST, ($urandom & 32'hFFF0_0000) | 32'd3);
        write_reg(REG_KP, ($urandom & 32'hFFFF_FF00) | 32'd255);
        send_event(KIND_BYTE, CH_DIST_LO, 1'b0);
        send_event(KIND_ENC_A, 8'h00, 1'b0);
        send_event(KIND_ENC_A, 8'h00, 1'b0);
        send_event(KIND_ENC_B, 8'h00, 1'b0);
        send_event(KIND_TICK, 8'h00, 1'b0);
        send_event(KIND_ENC_A, 8'h00, 1'b0);
        send_event(KIND_TICK, 8'h00, 1'b0);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    kp         = 8'd0;
                    dist_ticks = 20'd0;
                end
                1: begin
                    kp         = 8'd255;
                    dist_ticks = 20'hFFFFF;
                end
                default: begin
                    kp         = 8'($urandom_range(0, 255));
                    dist_ticks = 20'($urandom_range(0, 80));
                end
            endcase
            write_reg(REG_KP, ($urandom & 32'hFFFF_FF00) | {24'b0, kp});
            write_reg(REG_DIST, ($urandom & 32'hFFF0_0000) | {12'b0, dist_ticks});
            a_dir   = 1'($urandom_range(0, 1));
            b_dir   = 1'($urandom_range(0, 1));
            favored = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            for (item = 0; item < PHASE_ITEMS; item++) begin
                r = $urandom_range(0, 99);
                if (r < 14) begin
                    r = $urandom_range(0, 9);
                    if (r < 3)
                        ch = favored;
                    else if (r < 8)
                        ch = drive_char($urandom_range(0, 12));
                    else
                        ch = 8'($urandom_range(0, 255));
                    send_event(KIND_BYTE, ch, 1'($urandom_range(0, 1)));
                end else if (r < 46) begin
                    send_event(KIND_ENC_A, 8'($urandom_range(0, 255)),
                               ($urandom_range(0, 3) == 0) ? !a_dir : a_dir);
                end else if (r < 72) begin
                    send_event(KIND_ENC_B, 8'($urandom_range(0, 255)),
                               ($urandom_range(0, 3) == 0) ? !b_dir : b_dir);
                end else begin
                    send_event(KIND_TICK, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ddsc_pkg.sv
rtl/ddsc_sync.sv
rtl/differential_drive_sync_controller.sv
bench/drive_status_checker.sv
bench/tb_differential_drive_sync_controller.sv
